// File: rtl/psclk_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the polar
// sector color lookup block. No dependencies; every other file imports it.

package psclk_pkg;

	// Default configuration of the core.
	localparam int MAX_SECTORS_DEF     = 16;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 6;

	// Register port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W    = 5;

	// Reset values of the configuration registers.
	localparam logic [15:0]        IMAGE_SIZE_RST   = 16'd1000;
	localparam logic [COUNT_W-1:0] SECTOR_COUNT_RST = '0;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_SECTOR_COUNT = 2'd2
	} cfg_reg_t;

	// Item modes.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_POINT = 1'b1;

	// Angle sequencer states.
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROT,
		CS_MUL,
		CS_RND
	} cordic_state_t;

	// Input item.
	typedef struct packed {
		logic               mode;
		logic [3:0]         entry_index;
		logic [15:0]        sector_degrees;
		logic [7:0]         entry_red;
		logic [7:0]         entry_green;
		logic [7:0]         entry_blue;
		logic [7:0]         entry_alpha;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
	} psclk_in_t;

	// Result item.
	typedef struct packed {
		logic       hit;
		logic [3:0] sector;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} psclk_out_t;

	// Match status carried along the sector chain.
	typedef struct packed {
		logic        found;
		logic [3:0]  sector;
		logic [31:0] color;
	} psclk_match_t;

	// Palette write broadcast to every sector cell.
	typedef struct packed {
		logic        we;
		logic [3:0]  index;
		logic [15:0] width;
		logic [31:0] color;
	} psclk_load_t;

	// Arctangent of 2^-i as a binary angle, 2^32 per full turn.
	function automatic logic [31:0] atan_bin(input logic [4:0] idx);
		logic [31:0] val;
		begin
			case (idx)
				5'd0:    val = 32'h2000_0000;
				5'd1:    val = 32'h12E4_051E;
				5'd2:    val = 32'h09FB_385B;
				5'd3:    val = 32'h0511_11D4;
				5'd4:    val = 32'h028B_0D43;
				5'd5:    val = 32'h0145_D7E1;
				5'd6:    val = 32'h00A2_F61E;
				5'd7:    val = 32'h0051_7C55;
				5'd8:    val = 32'h0028_BE53;
				5'd9:    val = 32'h0014_5F2F;
				5'd10:   val = 32'h000A_2F98;
				5'd11:   val = 32'h0005_17CC;
				5'd12:   val = 32'h0002_8BE6;
				5'd13:   val = 32'h0001_45F3;
				5'd14:   val = 32'h0000_A2FA;
				5'd15:   val = 32'h0000_517D;
				5'd16:   val = 32'h0000_28BE;
				5'd17:   val = 32'h0000_145F;
				5'd18:   val = 32'h0000_0A2F;
				5'd19:   val = 32'h0000_0518;
				5'd20:   val = 32'h0000_028B;
				5'd21:   val = 32'h0000_0146;
				5'd22:   val = 32'h0000_00A3;
				5'd23:   val = 32'h0000_0051;
				default: val = 32'h0000_0000;
			endcase
			return val;
		end
	endfunction

endpackage

// File: rtl/psclk_cordic.sv
// Iterative vectoring CORDIC: polar angle of a point in fixed-point degrees.
// Depends on psclk_pkg for the state type and the arctangent table.

module psclk_cordic import psclk_pkg::*; #(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	localparam int FULL_TURN      = 360 << ANGLE_FRAC_BITS,
	localparam int ANG_W          = $clog2(FULL_TURN)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [23:0] px,
	input  logic signed [23:0] py,
	output logic               done,
	output logic [ANG_W-1:0]   angle
);

	localparam int CW     = 43;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int FULL_W = $clog2(FULL_TURN + 1);
	localparam int PROD_W = 32 + FULL_W;

	cordic_state_t          state_q, state_nx;
	logic [STEP_W-1:0]      step_q;
	logic signed [CW-1:0]   x_q, y_q;
	logic [31:0]            ang_q;
	logic                   axis_q, axis_neg_q;
	logic [PROD_W-1:0]      prod_q;

	logic signed [CW-1:0]   x_ext, y_ext, x_init, y_init;
	logic signed [CW-1:0]   xs, ys, x_nx, y_nx;
	logic [31:0]            ang_init, ang_nx, atan_val;
	logic                   last_step;
	logic [PROD_W:0]        rnd_sum;
	logic [FULL_W:0]        units;

	// Scale by 2^16 and turn half a circle when x is negative.
	assign x_ext    = {{(CW-40){px[23]}}, px, 16'b0};
	assign y_ext    = {{(CW-40){py[23]}}, py, 16'b0};
	assign x_init   = px[23] ? -x_ext : x_ext;
	assign y_init   = px[23] ? -y_ext : y_ext;
	assign ang_init = px[23] ? 32'h8000_0000 : 32'h0000_0000;

	// One micro-rotation, steering y toward zero.
	always_comb begin
		xs       = x_q >>> step_q;
		ys       = y_q >>> step_q;
		atan_val = atan_bin(5'(step_q));
		if (!y_q[CW-1]) begin
			x_nx   = x_q + ys;
			y_nx   = y_q - xs;
			ang_nx = ang_q + atan_val;
		end else begin
			x_nx   = x_q - ys;
			y_nx   = y_q + xs;
			ang_nx = ang_q - atan_val;
		end
	end

	assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			CS_IDLE: if (start) state_nx = CS_ROT;
			CS_ROT:  if (last_step) state_nx = CS_MUL;
			CS_MUL:  state_nx = CS_RND;
			CS_RND:  state_nx = CS_IDLE;
			default: state_nx = CS_IDLE;
		endcase
	end

	// Outputs: round the binary angle to degree units and wrap a full turn.
	always_comb begin
		rnd_sum = {1'b0, prod_q} + (PROD_W+1)'(64'h8000_0000);
		units   = rnd_sum[PROD_W:32];
		done    = (state_q == CS_RND);
		if (axis_q) begin
			angle = axis_neg_q ? ANG_W'(FULL_TURN / 2) : '0;
		end else if (units >= (FULL_W+1)'(FULL_TURN)) begin
			angle = '0;
		end else begin
			angle = units[ANG_W-1:0];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == CS_ROT) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					x_q        <= x_init;
					y_q        <= y_init;
					ang_q      <= ang_init;
					axis_q     <= (py == '0);
					axis_neg_q <= px[23];
				end
			end
			CS_ROT: begin
				x_q   <= x_nx;
				y_q   <= y_nx;
				ang_q <= ang_nx;
			end
			CS_MUL: begin
				prod_q <= PROD_W'(ang_q) * PROD_W'(FULL_TURN);
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/psclk_disc.sv
// Disc membership test on squared distances, two register stages.
// Depends on psclk_pkg, imported by wildcard.

module psclk_disc import psclk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [23:0] px,
	input  logic signed [23:0] py,
	input  logic [15:0]        image_width,
	input  logic [15:0]        image_height,
	output logic               in_disc
);

	logic signed [47:0] sq_x, sq_y;
	logic [15:0]        mn;
	logic [47:0]        xsq_s1, ysq_s1;
	logic [31:0]        mnsq_s1;
	logic               start_s1;
	logic               in_disc_q;

	assign mn   = (image_width < image_height) ? image_width : image_height;
	assign sq_x = px * px;
	assign sq_y = py * py;

	// Stage 1 squares, stage 2 compares the radius against the limit.
	always_ff @(posedge clk) begin
		if (start) begin
			xsq_s1  <= sq_x;
			ysq_s1  <= sq_y;
			mnsq_s1 <= mn * mn;
		end
		if (start_s1) begin
			in_disc_q <= ({1'b0, xsq_s1} + {1'b0, ysq_s1}) <= {3'b0, mnsq_s1, 14'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start;
		end
	end

	assign in_disc = in_disc_q;

endmodule

// File: rtl/psclk_cell.sv
// One sector cell: holds a palette entry and tests the passing angle token.
// Depends on psclk_pkg for the load and match structs.

module psclk_cell import psclk_pkg::*; #(
	parameter int CELL_IDX        = 0,
	parameter int ANG_W           = 15,
	parameter int START_W         = 26,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psclk_load_t        load,
	input  logic [COUNT_W-1:0] sector_count,
	input  logic               in_valid,
	input  logic [ANG_W-1:0]   in_angle,
	input  logic [START_W-1:0] in_start,
	input  psclk_match_t       in_match,
	output logic               out_valid,
	output logic [ANG_W-1:0]   out_angle,
	output logic [START_W-1:0] out_start,
	output psclk_match_t       out_match
);

	logic [15:0]        width_q;
	logic [31:0]        color_q;
	logic               valid_q;
	logic [ANG_W-1:0]   angle_q;
	logic [START_W-1:0] start_q;
	psclk_match_t       match_q;

	logic [START_W-1:0] w_ext, span_end, angle_ext;
	logic               active, hit_here;
	psclk_match_t       match_nx;

	// Palette entry storage.
	always_ff @(posedge clk) begin
		if (load.we && (int'(load.index) == CELL_IDX)) begin
			width_q <= load.width;
			color_q <= load.color;
		end
	end

	// Span test: start <= angle <= start + width, one unit of tolerance.
	always_comb begin
		w_ext     = START_W'(width_q) << ANGLE_FRAC_BITS;
		span_end  = in_start + w_ext;
		angle_ext = START_W'(in_angle);
		active    = int'(sector_count) > CELL_IDX;
		hit_here  = active && !in_match.found && (angle_ext >= in_start) &&
			(angle_ext <= span_end);
		if (hit_here) begin
			match_nx.found  = 1'b1;
			match_nx.sector = 4'(CELL_IDX);
			match_nx.color  = color_q;
		end else begin
			match_nx = in_match;
		end
	end

	// Token hand-off to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			angle_q <= in_angle;
			start_q <= span_end;
			match_q <= match_nx;
		end
	end

	assign out_valid = valid_q;
	assign out_angle = angle_q;
	assign out_start = start_q;
	assign out_match = match_q;

endmodule

// File: rtl/polar_sector_color_lookup_core.sv
// Path: a point result leaves the CORDIC iterations, then passes a register in every one
// of the MAX_SECTORS sector cells, the result holding stage and the output register.
// Input: one point is in work at a time, as the input waits until the previous result enters
// the output register; a load gives no result.
// Reset: control state clears, width and height become 1000, sector count 0; palette
// entries are undefined until loaded.

module polar_sector_color_lookup_core import psclk_pkg::*; #(
	parameter int MAX_SECTORS     = MAX_SECTORS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  psclk_in_t             in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output psclk_out_t            out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
	localparam int ANG_W     = $clog2(FULL_TURN);
	localparam int START_W   = 16 + ANGLE_FRAC_BITS + $clog2(MAX_SECTORS);

	logic [15:0]        image_width_q, image_height_q;
	logic [COUNT_W-1:0] sector_count_q;
	logic               busy_q;
	logic               res_valid_q, out_valid_q;
	psclk_out_t         res_q, out_q, res_nx;

	logic               in_xfer, point_start, res_move, in_disc;
	psclk_load_t        load;
	logic               cordic_done;
	logic [ANG_W-1:0]   cordic_angle;
	psclk_match_t       end_match;

	logic [MAX_SECTORS:0] chain_valid;
	logic [ANG_W-1:0]     chain_angle [MAX_SECTORS+1];
	logic [START_W-1:0]   chain_start [MAX_SECTORS+1];
	psclk_match_t         chain_match [MAX_SECTORS+1];

	assign cfg_ready   = 1'b1;
	assign in_ready    = !busy_q;
	assign in_xfer     = in_valid && in_ready;
	assign point_start = in_xfer && (in_data.mode == MODE_POINT);

	// Palette write broadcast.
	assign load.we    = in_xfer && (in_data.mode == MODE_LOAD);
	assign load.index = in_data.entry_index;
	assign load.width = in_data.sector_degrees;
	assign load.color = {in_data.entry_red, in_data.entry_green,
		in_data.entry_blue, in_data.entry_alpha};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_SIZE_RST;
			image_height_q <= IMAGE_SIZE_RST;
			sector_count_q <= SECTOR_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_SECTOR_COUNT: sector_count_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	psclk_cordic #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (point_start),
		.px     (in_data.point_x),
		.py     (in_data.point_y),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	psclk_disc u_disc (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (point_start),
		.px           (in_data.point_x),
		.py           (in_data.point_y),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.in_disc      (in_disc)
	);

	// Sector chain: the angle token visits one cell per cycle.
	assign chain_valid[0] = cordic_done;
	assign chain_angle[0] = cordic_angle;
	assign chain_start[0] = '0;
	assign chain_match[0] = '0;

	for (genvar g = 0; g < MAX_SECTORS; g++) begin : g_cell
		psclk_cell #(
			.CELL_IDX        (g),
			.ANG_W           (ANG_W),
			.START_W         (START_W),
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load         (load),
			.sector_count (sector_count_q),
			.in_valid     (chain_valid[g]),
			.in_angle     (chain_angle[g]),
			.in_start     (chain_start[g]),
			.in_match     (chain_match[g]),
			.out_valid    (chain_valid[g+1]),
			.out_angle    (chain_angle[g+1]),
			.out_start    (chain_start[g+1]),
			.out_match    (chain_match[g+1])
		);
	end

	// A hit needs both a sector and the disc; a miss is all zero.
	assign end_match = chain_match[MAX_SECTORS];

	always_comb begin
		res_nx = '0;
		if (end_match.found && in_disc) begin
			res_nx.hit       = 1'b1;
			res_nx.sector    = end_match.sector;
			res_nx.out_red   = end_match.color[31:24];
			res_nx.out_green = end_match.color[23:16];
			res_nx.out_blue  = end_match.color[15:8];
			res_nx.out_alpha = end_match.color[7:0];
		end
	end

	assign res_move = res_valid_q && (!out_valid_q || out_ready);

	// Result holding stage, output register and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (point_start) begin
				busy_q <= 1'b1;
			end else if (res_move) begin
				busy_q <= 1'b0;
			end
			if (chain_valid[MAX_SECTORS]) begin
				res_valid_q <= 1'b1;
			end else if (res_move) begin
				res_valid_q <= 1'b0;
			end
			if (res_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_valid[MAX_SECTORS]) begin
			res_q <= res_nx;
		end
		if (res_move) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Only one angle token may travel the chain at a time.
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_valid))
		else $error("more than one angle token in the sector chain");

	// A token in flight or a held result means a point is outstanding.
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((chain_valid != '0) || res_valid_q) |-> busy_q)
		else $error("point work in flight while the core is not busy");

	// A miss carries no sector and no color.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data == '0))
		else $error("miss result with nonzero fields");

	// A hit names a sector that is in use.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |-> (int'(out_data.sector) < int'(sector_count_q)))
		else $error("hit on a sector beyond the sector count");

endmodule
